[src/nrbeg_pkg.sv]
// ============================================================================
// nrbeg_pkg
// Shared widths, register indexes and queue types of the NAL RBSP
// Exp-Golomb decoder.
// ============================================================================
`default_nettype none

package nrbeg_pkg;

    // Field widths.
    localparam int BYTE_W        = 8;
    localparam int K_W           = 32;
    localparam int HDR_W         = 2;
    localparam int ZRUN_W        = 2;
    localparam int CODE_BITS_DEF = 32;

    // Depth of the queue between the byte front end and the bit back end.
    localparam int Q_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SKIP = 2'd1;

    localparam logic [HDR_W-1:0] HDR_SKIP_RST = 2'd1;

    // Emulation-prevention byte.
    localparam logic [BYTE_W-1:0] EPB_BYTE = 8'h03;

    // One classified byte waiting for the bit decoder.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
        logic              payload;
    } t_q_entry;

    // Write side of the queue.
    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_push;

endpackage

`default_nettype wire

[src/nrbeg_ifs.sv]
// ============================================================================
// nrbeg interfaces
// Valid/ready channels of the decoder: byte input, result output and the
// configuration write channel.
// ============================================================================
`default_nettype none

interface nrbeg_in_if;
    logic                         valid;
    logic                         ready;
    logic [nrbeg_pkg::BYTE_W-1:0] byte_value;
    logic                         last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface nrbeg_out_if;
    logic                             valid;
    logic                             ready;
    logic        [nrbeg_pkg::K_W-1:0] code_value;
    logic signed [nrbeg_pkg::K_W-1:0] signed_value;
    logic                             is_signed;
    logic                             prefix_error;
    logic                             last_of_byte;
    logic                             end_of_unit;

    modport source (output valid, output code_value, output signed_value,
                    output is_signed, output prefix_error, output last_of_byte,
                    output end_of_unit, input ready);
    modport sink   (input valid, input code_value, input signed_value,
                    input is_signed, input prefix_error, input last_of_byte,
                    input end_of_unit, output ready);
endinterface

interface nrbeg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nrbeg_pkg::CFG_IDX_W-1:0]  index;
    logic [nrbeg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/nrbeg_front.sv]
// ============================================================================
// nrbeg_front
// Byte front end: marks header bytes and emulation-prevention bytes as
// non-payload, tracks the payload zero run and queues every byte with its classification.
// ============================================================================
`default_nettype none

module nrbeg_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire [nrbeg_pkg::HDR_W-1:0]    i_header_skip,
    nrbeg_in_if.sink                      i_in,
    input  wire                           i_full,
    output nrbeg_pkg::t_q_push            o_push
);
    import nrbeg_pkg::*;

    logic [HDR_W-1:0]  r_header_left, n_header_left;
    logic [ZRUN_W-1:0] r_zero_run,    n_zero_run;
    logic              w_accept;
    logic              w_payload;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    // Classify the byte and update header count and zero run.
    always_comb begin
        n_header_left = r_header_left;
        n_zero_run    = r_zero_run;
        w_payload     = 1'b0;
        if (r_header_left != '0) begin
            n_header_left = r_header_left - HDR_W'(1);
        end else if (r_zero_run[1] && (i_in.byte_value == EPB_BYTE)) begin
            n_zero_run = '0;
        end else begin
            w_payload = 1'b1;
            if (i_in.byte_value == '0) begin
                if (!r_zero_run[1]) begin
                    n_zero_run = r_zero_run + ZRUN_W'(1);
                end
            end else begin
                n_zero_run = '0;
            end
        end
        // A unit end restarts header skipping and the zero run.
        if (i_in.last_byte) begin
            n_header_left = i_header_skip;
            n_zero_run    = '0;
        end
    end

    // Queue write.
    always_comb begin
        o_push.valid            = w_accept;
        o_push.entry.byte_value = i_in.byte_value;
        o_push.entry.last_byte  = i_in.last_byte;
        o_push.entry.payload    = w_payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_left <= HDR_SKIP_RST;
            r_zero_run    <= '0;
        end else if (w_accept) begin
            r_header_left <= n_header_left;
            r_zero_run    <= n_zero_run;
        end
    end

endmodule

`default_nettype wire

[src/nrbeg_queue.sv]
// ============================================================================
// nrbeg_queue
// Short FIFO of classified bytes between the front end and the bit decoder.
// ============================================================================
`default_nettype none

module nrbeg_queue (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire nrbeg_pkg::t_q_push   i_push,
    output logic                      o_full,
    output nrbeg_pkg::t_q_entry       o_head,
    output logic                      o_head_valid,
    input  wire                       i_pop
);
    import nrbeg_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_q_entry         r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full       = (r_count == CNT_W'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

`default_nettype wire

[src/nrbeg_back.sv]
// ============================================================================
// nrbeg_back
// Bit decoder: walks payload bytes MSB first, one bit per cycle while not
// stalled, and assembles Exp-Golomb codewords. A result waits in a holding
// register until the next result or the byte's end shows if it ends the byte.
// ============================================================================
`default_nettype none

module nrbeg_back #(
    parameter int CODE_BITS = nrbeg_pkg::CODE_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire nrbeg_pkg::t_q_entry  i_head,
    input  wire                       i_head_valid,
    output logic                      o_pop,
    input  wire                       i_signed_mode,
    nrbeg_out_if.source               o_out
);
    import nrbeg_pkg::*;

    localparam int PZ_W = $clog2(CODE_BITS);

    // Codeword state.
    logic [PZ_W-1:0]      r_prefix_zeros, n_prefix_zeros;
    logic                 r_in_suffix,    n_in_suffix;
    logic [PZ_W-1:0]      r_suffix_left,  n_suffix_left;
    logic [CODE_BITS-1:0] r_suffix_accum, n_suffix_accum;
    logic [2:0]           r_bit_idx,      n_bit_idx;

    // Holding register for the newest result.
    logic           r_pend_valid, n_pend_valid;
    logic           r_pend_final, n_pend_final;
    logic [K_W-1:0] r_pend_k,     n_pend_k;
    logic           r_pend_err,   n_pend_err;
    logic           r_pend_eou,   n_pend_eou;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [K_W-1:0]        r_out_code,  n_out_code;
    logic signed [K_W-1:0] r_out_sv,    n_out_sv;
    logic                  r_out_sgn,   n_out_sgn;
    logic                  r_out_err,   n_out_err;
    logic                  r_out_lob,   n_out_lob;
    logic                  r_out_eou,   n_out_eou;

    logic                 w_bit;
    logic                 w_gen;
    logic                 w_err;
    logic [K_W-1:0]       w_k;
    logic [CODE_BITS-1:0] w_accum_shift;
    logic                 w_out_free;
    logic                 w_pend_move;
    logic                 w_advance;
    logic                 w_last_bit;
    logic                 w_byte_done;
    logic [K_W-1:0]       w_half;

    assign w_bit         = i_head.byte_value[~r_bit_idx];
    assign w_accum_shift = {r_suffix_accum[CODE_BITS-2:0], w_bit};
    assign w_last_bit    = (r_bit_idx == 3'd7);
    assign w_out_free    = !r_out_valid || o_out.ready;

    // Codeword step for the current bit.
    always_comb begin
        w_gen          = 1'b0;
        w_err          = 1'b0;
        w_k            = '0;
        n_prefix_zeros = r_prefix_zeros;
        n_in_suffix    = r_in_suffix;
        n_suffix_left  = r_suffix_left;
        n_suffix_accum = r_suffix_accum;
        if (i_head_valid && i_head.payload) begin
            if (r_in_suffix) begin
                n_suffix_accum = w_accum_shift;
                n_suffix_left  = r_suffix_left - PZ_W'(1);
                if (r_suffix_left == PZ_W'(1)) begin
                    w_gen          = 1'b1;
                    w_k            = ~({K_W{1'b1}} << r_prefix_zeros) + K_W'(w_accum_shift);
                    n_prefix_zeros = '0;
                    n_in_suffix    = 1'b0;
                    n_suffix_left  = '0;
                    n_suffix_accum = '0;
                end
            end else if (!w_bit) begin
                if (r_prefix_zeros == PZ_W'(CODE_BITS - 1)) begin
                    // Prefix too long: report it and start over.
                    w_gen          = 1'b1;
                    w_err          = 1'b1;
                    n_prefix_zeros = '0;
                end else begin
                    n_prefix_zeros = r_prefix_zeros + PZ_W'(1);
                end
            end else if (r_prefix_zeros == '0) begin
                w_gen = 1'b1;
            end else begin
                n_in_suffix    = 1'b1;
                n_suffix_left  = r_prefix_zeros;
                n_suffix_accum = '0;
            end
        end
    end

    // Flow control between queue head, holding register and output.
    always_comb begin
        w_pend_move = r_pend_valid && w_out_free && (r_pend_final || w_gen);
        w_advance   = i_head_valid &&
                      (!i_head.payload || !w_gen || !r_pend_valid || w_pend_move);
        w_byte_done = w_advance && (!i_head.payload || w_last_bit);
        o_pop       = w_byte_done;
        n_bit_idx   = r_bit_idx;
        if (w_advance && i_head.payload) begin
            n_bit_idx = r_bit_idx + 3'd1;
        end
    end

    // Holding register.
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_final = r_pend_final;
        n_pend_k     = r_pend_k;
        n_pend_err   = r_pend_err;
        n_pend_eou   = r_pend_eou;
        if (w_advance && w_gen) begin
            n_pend_valid = 1'b1;
            n_pend_final = w_last_bit;
            n_pend_k     = w_k;
            n_pend_err   = w_err;
            n_pend_eou   = i_head.last_byte;
        end else if (w_pend_move) begin
            n_pend_valid = 1'b0;
        end else if (w_advance && i_head.payload && w_last_bit && r_pend_valid) begin
            n_pend_final = 1'b1;
        end
    end

    // Output register; the se mapping is formed on the way out.
    always_comb begin
        w_half      = r_pend_k >> 1;
        n_out_valid = r_out_valid;
        n_out_code  = r_out_code;
        n_out_sv    = r_out_sv;
        n_out_sgn   = r_out_sgn;
        n_out_err   = r_out_err;
        n_out_lob   = r_out_lob;
        n_out_eou   = r_out_eou;
        if (w_pend_move) begin
            n_out_valid = 1'b1;
            n_out_code  = r_pend_k;
            n_out_sv    = r_pend_k[0] ? $signed(w_half + K_W'(1)) : $signed(K_W'(0) - w_half);
            n_out_sgn   = i_signed_mode;
            n_out_err   = r_pend_err;
            n_out_lob   = r_pend_final;
            n_out_eou   = r_pend_eou;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.code_value   = r_out_code;
    assign o_out.signed_value = r_out_sv;
    assign o_out.is_signed    = r_out_sgn;
    assign o_out.prefix_error = r_out_err;
    assign o_out.last_of_byte = r_out_lob;
    assign o_out.end_of_unit  = r_out_eou;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_zeros <= '0;
            r_in_suffix    <= 1'b0;
            r_suffix_left  <= '0;
            r_suffix_accum <= '0;
            r_bit_idx      <= '0;
            r_pend_valid   <= 1'b0;
            r_pend_final   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_byte_done && i_head.last_byte) begin
                // A unit end drops any partial codeword.
                r_prefix_zeros <= '0;
                r_in_suffix    <= 1'b0;
                r_suffix_left  <= '0;
                r_suffix_accum <= '0;
            end else if (w_advance) begin
                r_prefix_zeros <= n_prefix_zeros;
                r_in_suffix    <= n_in_suffix;
                r_suffix_left  <= n_suffix_left;
                r_suffix_accum <= n_suffix_accum;
            end
            r_bit_idx    <= n_bit_idx;
            r_pend_valid <= n_pend_valid;
            r_pend_final <= n_pend_final;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_pend_k   <= n_pend_k;
        r_pend_err <= n_pend_err;
        r_pend_eou <= n_pend_eou;
        r_out_code <= n_out_code;
        r_out_sv   <= n_out_sv;
        r_out_sgn  <= n_out_sgn;
        r_out_err  <= n_out_err;
        r_out_lob  <= n_out_lob;
        r_out_eou  <= n_out_eou;
    end

endmodule

`default_nettype wire

[src/nal_rbsp_exp_golomb_decoder.sv]
// ============================================================================
// nal_rbsp_exp_golomb_decoder
// NAL unit Exp-Golomb ue/se decoder with header skip and emulation-prevention
// byte removal.
// ============================================================================
// Usage:
//   i_in carries one raw NAL byte per beat, last_byte set on the unit's final
//   byte. o_out carries one beat per decoded codeword: ue value, se mapping,
//   mode flag, prefix error, last result of its byte and end of unit.
//   i_cfg writes signed_mode (index 0) and header_skip (index 1); it is always
//   ready. The user must write it only while the decoder is idle (unchecked).
// Timing:
//   With the queue empty, an accepted byte is written to the queue and its
//   first bit is then decoded from the queue head. A payload byte is decoded
//   one bit per cycle unless a full holding register stalls it; a header or
//   emulation byte is popped without decoding. Sustained input rate is thus
//   set by the single-bit decode loop. A result is held until the next result
//   of its byte, or the byte's last bit, shows whether it ends the byte; it
//   then moves to the output register and is offered on o_out unless stalled.
//   A two-entry queue lets new bytes be taken while the decoder works.
// Reset and stall:
//   Synchronous reset empties the queue, clears the codeword state and loads
//   header_skip = 1 and signed_mode = 0. When o_out stalls, the output and
//   holding registers fill, the decoder halts, then the queue fills and
//   i_in.ready drops. No result is lost.
// ============================================================================
`default_nettype none

module nal_rbsp_exp_golomb_decoder #(
    parameter int CODE_BITS = nrbeg_pkg::CODE_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    nrbeg_in_if.sink     i_in,
    nrbeg_out_if.source  o_out,
    nrbeg_cfg_if.sink    i_cfg
);
    import nrbeg_pkg::*;

    logic             r_signed_mode, n_signed_mode;
    logic [HDR_W-1:0] r_header_skip, n_header_skip;

    t_q_push  w_push;
    t_q_entry w_head;
    logic     w_full;
    logic     w_head_valid;
    logic     w_pop;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_signed_mode = r_signed_mode;
        n_header_skip = r_header_skip;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SIGNED_MODE: n_signed_mode = i_cfg.data[0];
                REG_HEADER_SKIP: n_header_skip = i_cfg.data[HDR_W-1:0];
                default: begin
                    n_signed_mode = r_signed_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
            r_header_skip <= HDR_SKIP_RST;
        end else begin
            r_signed_mode <= n_signed_mode;
            r_header_skip <= n_header_skip;
        end
    end

    nrbeg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_header_skip (r_header_skip),
        .i_in          (i_in),
        .i_full        (w_full),
        .o_push        (w_push)
    );

    nrbeg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_full       (w_full),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    nrbeg_back #(
        .CODE_BITS (CODE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_valid  (w_head_valid),
        .o_pop         (w_pop),
        .i_signed_mode (r_signed_mode),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

[src/nrbeg_checker.sv]
// ============================================================================
// nrbeg_checker
// Port-level checks of the decoder's result channel, bound to the top level.
// ============================================================================
`default_nettype none

module nrbeg_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_out_valid,
    input  wire                                i_out_ready,
    input  wire        [nrbeg_pkg::K_W-1:0]    i_code_value,
    input  wire signed [nrbeg_pkg::K_W-1:0]    i_signed_value,
    input  wire                                i_prefix_error
);
    import nrbeg_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // An error result carries zero values.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_prefix_error |-> (i_code_value == '0) && (i_signed_value == '0))
        else $error("error result with nonzero value");

    // The se mapping of an even ue value is its negated half.
    a_se_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_code_value[0] |->
            (i_signed_value == $signed(K_W'(0) - (i_code_value >> 1))))
        else $error("se mapping wrong for even value");

endmodule

bind nal_rbsp_exp_golomb_decoder nrbeg_checker u_nrbeg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_code_value   (o_out.code_value),
    .i_signed_value (o_out.signed_value),
    .i_prefix_error (o_out.prefix_error)
);

`default_nettype wire
